### sv/srr_pkg.sv
// Shared types and constants for the sample rate ratio reducer.
// Depends on nothing; every other file imports this package.
package srr_pkg;

   localparam int RATE_BITS = 20;
   localparam int FIELD_W = 20;
   localparam int CNT_W = $clog2(RATE_BITS + 1);

   typedef logic [RATE_BITS-1:0] rate_type;
   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      field_type source_rate;
      field_type target_rate;
   } req_word_type;

   typedef struct packed {
      field_type up_factor;
      field_type down_factor;
      logic rates_differ;
      logic bad_rates;
   } rsp_word_type;

   typedef enum logic [1:0] {
      OP_MOD = 2'd0,
      OP_UP = 2'd1,
      OP_DOWN = 2'd2
   } op_type;

   typedef struct packed {
      logic load;
      logic start;
      op_type start_op;
      logic take;
      op_type take_op;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic both_zero;
      logic y_zero;
      logic div_done;
   } sts_type;

endpackage

### sv/srr_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on srr_pkg.
module srr_divider (
   input logic clock,
   input logic reset,
   input logic start,
   input srr_pkg::rate_type dividend,
   input srr_pkg::rate_type divisor,
   output logic done,
   output srr_pkg::rate_type quotient,
   output srr_pkg::rate_type remainder
);
   import srr_pkg::*;

   rate_type rem_ff, rem_in;
   rate_type quo_ff, quo_in;
   rate_type div_ff, div_in;
   cnt_type cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [RATE_BITS:0] trial;
   logic [RATE_BITS:0] diff;

   always_comb begin
      trial = {rem_ff, quo_ff[RATE_BITS-1]};
      diff = trial - {1'b0, div_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
         cnt_in = CNT_W'(RATE_BITS);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[RATE_BITS-1:0];
            quo_in = {quo_ff[RATE_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[RATE_BITS-1:0];
            quo_in = {quo_ff[RATE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      start |=> !done_ff && busy_ff)
      else $error("divider did not restart");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> rem_ff < div_ff)
      else $error("divider remainder not reduced");

endmodule

### sv/srr_datapath.sv
// Datapath: operand registers, Euclid step, factor registers and result word.
// Depends on srr_pkg and srr_divider.
module srr_datapath (
   input logic clock,
   input logic reset,
   input srr_pkg::cmd_type cmd,
   output srr_pkg::sts_type sts,
   input srr_pkg::req_word_type req_payload,
   output srr_pkg::rsp_word_type rsp_payload
);
   import srr_pkg::*;

   rate_type src_ff, dst_ff, x_ff, y_ff, up_ff, down_ff;
   rsp_word_type out_ff;
   rate_type dividend, divisor, quotient, remainder;
   logic div_done;

   always_comb begin
      case (cmd.start_op)
         OP_MOD: begin
            dividend = x_ff;
            divisor = y_ff;
         end
         OP_UP: begin
            dividend = dst_ff;
            divisor = x_ff;
         end
         OP_DOWN: begin
            dividend = src_ff;
            divisor = x_ff;
         end
         default: begin
            dividend = x_ff;
            divisor = y_ff;
         end
      endcase
   end

   srr_divider u_divider (
      .clock(clock),
      .reset(reset),
      .start(cmd.start),
      .dividend(dividend),
      .divisor(divisor),
      .done(div_done),
      .quotient(quotient),
      .remainder(remainder)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff <= RATE_BITS'(req_payload.source_rate);
         dst_ff <= RATE_BITS'(req_payload.target_rate);
         x_ff <= RATE_BITS'(req_payload.source_rate);
         y_ff <= RATE_BITS'(req_payload.target_rate);
         up_ff <= '0;
         down_ff <= '0;
      end else if (cmd.take) begin
         case (cmd.take_op)
            OP_MOD: begin
               x_ff <= y_ff;
               y_ff <= remainder;
            end
            OP_UP: up_ff <= quotient;
            OP_DOWN: down_ff <= quotient;
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         out_ff.up_factor <= FIELD_W'(up_ff);
         out_ff.down_factor <= FIELD_W'(down_ff);
         out_ff.rates_differ <= (src_ff != dst_ff);
         out_ff.bad_rates <= (src_ff == '0) && (dst_ff == '0);
      end
   end

   assign sts.both_zero = (src_ff == '0) && (dst_ff == '0);
   assign sts.y_zero = (y_ff == '0);
   assign sts.div_done = div_done;
   assign rsp_payload = out_ff;

endmodule

### sv/srr_ctrl.sv
// Controller: sequences the Euclid loop and the two final divisions,
// and owns the result valid flag. Depends on srr_pkg.
module srr_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input logic rsp_stall,
   output srr_pkg::cmd_type cmd,
   input srr_pkg::sts_type sts
);
   import srr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_SPARE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cmd = '0;
      cmd.start_op = OP_MOD;
      cmd.take_op = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.both_zero) begin
               state_in = ST_FINISH;
            end else if (sts.y_zero) begin
               cmd.start = 1'b1;
               cmd.start_op = OP_UP;
               op_in = OP_UP;
               state_in = ST_DIV;
            end else begin
               cmd.start = 1'b1;
               cmd.start_op = OP_MOD;
               op_in = OP_MOD;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.take = 1'b1;
               case (op_ff)
                  OP_MOD: state_in = ST_CHECK;
                  OP_UP: begin
                     cmd.start = 1'b1;
                     cmd.start_op = OP_DOWN;
                     op_in = OP_DOWN;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_MOD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten while waiting");
   a_take_on_done: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> sts.div_done)
      else $error("divider result taken before done");
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_CHECK)
      else $error("accepted word not checked");

endmodule

### sv/sample_rate_ratio_reducer_core.sv
// Top level of the sample rate ratio reducer: controller plus datapath.
// Depends on srr_pkg, srr_ctrl and srr_datapath.
//
//   Channel  Direction  Word           Handshake
//   req      in         req_word_type  req_valid / req_stall
//   rsp      out        rsp_word_type  rsp_valid / rsp_stall
//
// The Euclid steps and the two final divisions share one serial divider,
// one bit per cycle. Both rates zero skips the divider.
// Reset is synchronous and clears the controller and divider control state.
// A finished result waits in the output register while the next word is taken.
module sample_rate_ratio_reducer_core (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input srr_pkg::req_word_type req_payload,
   output logic rsp_valid,
   input logic rsp_stall,
   output srr_pkg::rsp_word_type rsp_payload
);
   import srr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   srr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd(cmd),
      .sts(sts)
   );

   srr_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_payload(req_payload),
      .rsp_payload(rsp_payload)
   );

endmodule
